// File: hw/rtl/swmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_pkg: shared definitions for the sliding window min/max block
// Register width, parameter defaults and the control/status words that pass
// between the top level and the two deque engines.
// ----------------------------------------------------------------------------
package swmm_pkg;

  // Width of the window length register
  localparam int unsigned CFG_W            = 11;

  // Defaults for the top level parameters
  localparam int unsigned WINDOW_MAX_DEF   = 1024;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  // Command word from the top level to a deque engine
  typedef struct packed {
    logic start;     // begin work on one sample
    logic clear;     // empty the deque before the sample
    logic want_min;  // 1: increasing deque (min), 0: decreasing deque (max)
  } dq_ctl_t;

  // Status word from a deque engine
  typedef struct packed {
    logic busy;      // sample in progress, front value not yet final
  } dq_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/swmm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_if: stream channels of the sliding window min/max block
// Valid/ready channels for the sample words going in and the min/max words
// coming out. A word moves on a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface swmm_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swmm_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_min;
  logic signed [SAMPLE_WIDTH-1:0] window_max;

  modport source (output valid, output window_min, output window_max, input ready);
  modport sink   (input valid, input window_min, input window_max, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sliding_window_min_max.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_min_max: running minimum and maximum over a sample window
// Each accepted sample word updates an increasing and a decreasing deque;
// once the window has filled, each sample yields one min/max word.
// ----------------------------------------------------------------------------
// A sample passes both deques, and the output step once the window has
// filled, before the next is accepted. The deques work side by side; the
// slower sets the pace, taking longer per popped back entry and when an
// aged-out front entry is replaced by a read from its memory. Each memory
// reads one entry per cycle. A finished min/max word waits in an output
// register while the next sample is taken; a new word that finds it still
// occupied holds the input until the old word is taken. The deque memories
// hold no reset value and need no clearing pass. window_len is written via
// cfg_we_i/cfg_wdata_i; the user must write it only while the block is idle,
// which the block does not enforce. 0 acts as 1 and values above WINDOW_MAX
// act as WINDOW_MAX. Restart empties both deques before its own sample.
// ----------------------------------------------------------------------------
module sliding_window_min_max #(
  parameter int unsigned WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [swmm_pkg::CFG_W-1:0] cfg_wdata_i,
  swmm_in_if.sink                         in_i,
  swmm_out_if.source                      out_o
);
  import swmm_pkg::*;

  localparam int unsigned PW   = $clog2(2 * WINDOW_MAX);
  localparam int unsigned KW   = (CFG_W > PW) ? CFG_W : PW;
  localparam int unsigned PMOD = 2 * WINDOW_MAX;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_OUT  = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [CFG_W-1:0]               win_len_q;
  logic [PW-1:0]                  cnt_q, cnt_d;
  logic                           full_q, full_d;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] min_q, min_d;
  logic signed [SAMPLE_WIDTH-1:0] max_q, max_d;

  logic                           accept;
  logic [KW-1:0]                  k_wide;
  logic [PW-1:0]                  k_eff;
  logic [PW-1:0]                  pos_cur;
  logic [PW:0]                    pos_nxt1;

  dq_ctl_t                        min_ctl, max_ctl;
  dq_stat_t                       min_stat, max_stat;
  logic signed [SAMPLE_WIDTH-1:0] min_front, max_front;

  assign in_i.ready = (state_q == T_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Clamp the window length into 1..WINDOW_MAX
  always_comb begin
    k_wide = KW'(win_len_q);
    if (k_wide == '0) begin
      k_wide = KW'(1);
    end else if (k_wide > KW'(WINDOW_MAX)) begin
      k_wide = KW'(WINDOW_MAX);
    end
  end
  assign k_eff = k_wide[PW-1:0];

  // Position of this sample, restart begins a new count
  assign pos_cur  = in_i.restart ? '0 : cnt_q;
  assign pos_nxt1 = (PW + 1)'(pos_cur) + (PW + 1)'(1);

  assign min_ctl = '{start: accept, clear: in_i.restart, want_min: 1'b1};
  assign max_ctl = '{start: accept, clear: in_i.restart, want_min: 1'b0};

  swmm_deque #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_min_dq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (min_ctl),
    .sample_i (in_i.sample),
    .pos_i    (pos_cur),
    .k_i      (k_eff),
    .stat_o   (min_stat),
    .front_o  (min_front)
  );

  swmm_deque #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_max_dq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (max_ctl),
    .sample_i (in_i.sample),
    .pos_i    (pos_cur),
    .k_i      (k_eff),
    .stat_o   (max_stat),
    .front_o  (max_front)
  );

  // Sequence: accept, wait for both deques, hand the word to the output once the window has filled
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_o.ready;
    min_d       = min_q;
    max_d       = max_q;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          cnt_d   = (pos_nxt1 == (PW + 1)'(PMOD)) ? '0 : pos_nxt1[PW-1:0];
          full_d  = (full_q && !in_i.restart) || (pos_nxt1 >= (PW + 1)'(k_eff));
          state_d = T_RUN;
        end
      end
      T_RUN: begin
        if (!min_stat.busy && !max_stat.busy) begin
          state_d = full_q ? T_OUT : T_IDLE;
        end
      end
      T_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          min_d       = min_front;
          max_d       = max_front;
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  // Control state and window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      cnt_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      win_len_q   <= CFG_W'(1);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        win_len_q <= cfg_wdata_i;
      end
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.window_min = min_q;
  assign out_o.window_max = max_q;

`ifndef SYNTHESIS
  // Both deques start work on the cycle after a sample is taken
  a_dq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (min_stat.busy && max_stat.busy))
    else $error("deque did not start after sample accept");

  // The filled flag only clears on a restart sample
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(full_q) |-> $past(accept && in_i.restart))
    else $error("window full flag dropped without restart");

  // A result is only staged once the window has filled
  a_out_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_OUT) |-> full_q)
    else $error("result staged before window filled");

  // Position counter stays below twice the window size
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW + 1)'(cnt_q) < (PW + 1)'(PMOD))
    else $error("position counter out of range");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/swmm_deque.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_deque: one monotonic deque held in a synchronous memory
// Stores (value, position) entries in a circular buffer. Per sample it pops
// back entries that the new value beats or ties, drops an aged-out front
// entry, then pushes the sample. Back and front entries are mirrored in
// registers so only deeper entries need a memory read.
// ----------------------------------------------------------------------------
module swmm_deque #(
  parameter int unsigned WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire swmm_pkg::dq_ctl_t                     ctl_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  wire logic [$clog2(2*WINDOW_MAX)-1:0]       pos_i,
  input  wire logic [$clog2(2*WINDOW_MAX)-1:0]       k_i,
  output swmm_pkg::dq_stat_t                         stat_o,
  output logic signed [SAMPLE_WIDTH-1:0]             front_o
);
  import swmm_pkg::*;

  localparam int unsigned PW    = $clog2(2 * WINDOW_MAX);   // position width
  localparam int unsigned AW    = $clog2(WINDOW_MAX);       // memory address
  localparam int unsigned SZW   = $clog2(WINDOW_MAX + 1);   // occupancy
  localparam int unsigned IW    = SZW + 1;                  // slot sum
  localparam int unsigned AGW   = PW + 2;                   // age arithmetic
  localparam int unsigned EW    = SAMPLE_WIDTH + PW;        // memory entry
  localparam int unsigned PMOD  = 2 * WINDOW_MAX;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BACK  = 3'd1;
  localparam logic [2:0] S_AGE   = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  // Circular buffer index of the entry ofs places behind head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [SZW-1:0] ofs);
    logic [IW-1:0] sum;
    sum = IW'(head) + IW'(ofs);
    if (sum >= IW'(WINDOW_MAX)) begin
      sum = sum - IW'(WINDOW_MAX);
    end
    return sum[AW-1:0];
  endfunction

  logic [2:0]                     state_q, state_d;
  logic [AW-1:0]                  head_q, head_d;
  logic [SZW-1:0]                 size_q, size_d;
  logic                           use_reg_q, use_reg_d;
  logic signed [SAMPLE_WIDTH-1:0] s_q, s_d;
  logic [PW-1:0]                  pos_q, pos_d;
  logic [PW-1:0]                  k_q, k_d;
  logic                           min_q, min_d;
  logic signed [SAMPLE_WIDTH-1:0] back_q, back_d;
  logic signed [SAMPLE_WIDTH-1:0] front_val_q, front_val_d;
  logic [PW-1:0]                  front_pos_q, front_pos_d;

  logic [EW-1:0]                  mem [WINDOW_MAX];
  logic [EW-1:0]                  rd_q;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [EW-1:0]                  wr_data;

  logic signed [SAMPLE_WIDTH-1:0] rd_val;
  logic [PW-1:0]                  rd_pos;
  logic signed [SAMPLE_WIDTH-1:0] bval;
  logic                           pop;
  logic [AGW-1:0]                 age_sum;
  logic [AGW-1:0]                 age_mod;
  logic [AGW-1:0]                 age;
  logic                           drop;
  logic [AW-1:0]                  head_inc;

  assign rd_val = $signed(rd_q[EW-1:PW]);
  assign rd_pos = rd_q[PW-1:0];

  // Compare against the cached back entry first, then against memory reads
  assign bval = use_reg_q ? back_q : rd_val;
  assign pop  = min_q ? (s_q <= bval) : (s_q >= bval);

  // Age of the front entry, positions wrap modulo twice the window size
  assign age_sum = AGW'(pos_q) + AGW'(PMOD) - AGW'(front_pos_q);
  assign age_mod = (age_sum >= AGW'(PMOD)) ? (age_sum - AGW'(PMOD)) : age_sum;
  assign age     = age_mod + AGW'(1);
  assign drop    = (size_q != '0) &&
                   ((age > AGW'(k_q)) || (size_q == SZW'(WINDOW_MAX)));

  assign head_inc = (head_q == AW'(WINDOW_MAX - 1)) ? '0 : (head_q + AW'(1));

  // Sequence one sample: pop back, age front, push
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    size_d      = size_q;
    use_reg_d   = use_reg_q;
    s_d         = s_q;
    pos_d       = pos_q;
    k_d         = k_q;
    min_d       = min_q;
    back_d      = back_q;
    front_val_d = front_val_q;
    front_pos_d = front_pos_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = {s_q, pos_q};
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          s_d       = sample_i;
          pos_d     = pos_i;
          k_d       = k_i;
          min_d     = ctl_i.want_min;
          use_reg_d = 1'b1;
          if (ctl_i.clear) begin
            head_d = '0;
            size_d = '0;
          end
          state_d = S_BACK;
        end
      end
      S_BACK: begin
        if (size_q == '0) begin
          state_d = S_AGE;
        end else if (pop) begin
          size_d    = size_q - SZW'(1);
          use_reg_d = 1'b0;
          // fetch the entry that becomes the new back
          if (size_q > SZW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = slot(head_q, size_q - SZW'(2));
          end
        end else begin
          state_d = S_AGE;
        end
      end
      S_AGE: begin
        if (drop) begin
          head_d = head_inc;
          size_d = size_q - SZW'(1);
          if (size_q > SZW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = head_inc;
            state_d = S_FRONT;
          end else begin
            state_d = S_PUSH;
          end
        end else begin
          state_d = S_PUSH;
        end
      end
      S_FRONT: begin
        front_val_d = rd_val;
        front_pos_d = rd_pos;
        state_d     = S_PUSH;
      end
      S_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = slot(head_q, size_q);
        size_d  = size_q + SZW'(1);
        back_d  = s_q;
        if (size_q == '0) begin
          front_val_d = s_q;
          front_pos_d = pos_q;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      size_q    <= '0;
      use_reg_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      size_q    <= size_d;
      use_reg_q <= use_reg_d;
    end
  end

  // Sample, limits and cached end entries
  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    pos_q       <= pos_d;
    k_q         <= k_d;
    min_q       <= min_d;
    back_q      <= back_d;
    front_val_q <= front_val_d;
    front_pos_q <= front_pos_d;
  end

  // Entry storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign front_o     = front_val_q;

endmodule
`default_nettype wire

// File: tb/tb_sliding_window_min_max.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max: self-checking bench for the window min/max block
// A queue-fed driver pushes sample words into the block. Each accepted word
// runs through a local pair of monotonic deques that predicts the min/max word
// it causes. A monitor compares every result word against the oldest
// prediction. Directed edge cases come first, then random phases over many
// window lengths, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_sliding_window_min_max;
  timeunit 1ns;
  timeprecision 1ps;

  import swmm_pkg::*;

  localparam int unsigned SW         = SAMPLE_WIDTH_DEF;
  localparam int unsigned WMAX       = WINDOW_MAX_DEF;
  localparam int unsigned POS_MOD    = 2 * WMAX;
  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned HOLD_AT    = 100;
  localparam int unsigned HOLD_LEN   = 400;

  // Deque selectors
  localparam int LO_DQ = 0;
  localparam int HI_DQ = 1;

  // Sample value patterns
  localparam int ST_WIDE    = 0;
  localparam int ST_NARROW  = 1;
  localparam int ST_EXTREME = 2;
  localparam int ST_RAMP    = 3;
  localparam int ST_MIX     = 4;

  typedef logic signed [SW-1:0] sample_t;
  typedef struct packed {
    logic    restart;
    sample_t sample;
  } sample_word_t;
  typedef struct packed {
    sample_t lo;
    sample_t hi;
  } minmax_word_t;

  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  swmm_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  swmm_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

  sliding_window_min_max #(
    .WINDOW_MAX  (WMAX),
    .SAMPLE_WIDTH(SW)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sample_word_t sample_backlog[$];
  minmax_word_t minmax_due[$];
  int unsigned  queued = 0;
  int unsigned  fails = 0;
  int unsigned  send_idle_pct = 12;
  int unsigned  recv_idle_pct = 46;

  // Predictor state: two deques of value and position, window length, count
  sample_t      dq_val[2][WMAX];
  int unsigned  dq_pos[2][WMAX];
  int unsigned  dq_head[2] = '{0, 0};
  int unsigned  dq_size[2] = '{0, 0};
  int unsigned  win_len = 1;
  int unsigned  seq_count = 0;
  bit           seq_full = 1'b0;
  // Most back entries the last accepted sample may pop in either deque
  int unsigned  work_bound = 0;

  function automatic int unsigned eff_window(input int unsigned v);
    if (v == 0) return 1;
    if (v > WMAX) return WMAX;
    return v;
  endfunction

  // Pop dominated back entries, age out the front, push the new sample
  task automatic advance_deque(input int d, input sample_t s, input int unsigned pos,
                               input int unsigned k);
    bit          popping;
    sample_t     back;
    int unsigned age;
    popping = 1'b1;
    while (popping && dq_size[d] > 0) begin
      back = dq_val[d][(dq_head[d] + dq_size[d] - 1) % WMAX];
      if (d == LO_DQ ? (s <= back) : (s >= back)) begin
        dq_size[d]--;
      end else begin
        popping = 1'b0;
      end
    end
    if (dq_size[d] > 0) begin
      age = ((pos + POS_MOD - dq_pos[d][dq_head[d]]) % POS_MOD) + 1;
      if (age > k) begin
        dq_head[d] = (dq_head[d] + 1) % WMAX;
        dq_size[d]--;
      end
    end
    if (dq_size[d] >= WMAX) begin
      dq_head[d] = (dq_head[d] + 1) % WMAX;
      dq_size[d]--;
    end
    dq_val[d][(dq_head[d] + dq_size[d]) % WMAX] = s;
    dq_pos[d][(dq_head[d] + dq_size[d]) % WMAX] = pos;
    dq_size[d]++;
  endtask

  // Update the window with one accepted sample and queue the min/max it yields
  task automatic track_window(input sample_t s, input logic restart);
    int unsigned  k;
    int unsigned  pos;
    minmax_word_t w;
    if (restart) begin
      dq_head   = '{0, 0};
      dq_size   = '{0, 0};
      seq_count = 0;
      seq_full  = 1'b0;
    end
    work_bound = (dq_size[LO_DQ] > dq_size[HI_DQ]) ? dq_size[LO_DQ] : dq_size[HI_DQ];
    k   = eff_window(win_len);
    pos = seq_count;
    advance_deque(LO_DQ, s, pos, k);
    advance_deque(HI_DQ, s, pos, k);
    if (!seq_full && pos + 1 >= k) seq_full = 1'b1;
    seq_count = (pos + 1) % POS_MOD;
    if (seq_full) begin
      w.lo = dq_val[LO_DQ][dq_head[LO_DQ]];
      w.hi = dq_val[HI_DQ][dq_head[HI_DQ]];
      minmax_due.push_back(w);
    end
  endtask

  // Sample driver: record the accepted word, then offer the next one or idle
  always @(posedge clk or negedge rst_n) begin : drive_samples
    sample_word_t nxt;
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.sample  <= '0;
      in_if.restart <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        track_window(in_if.sample, in_if.restart);
      end
      if (!in_if.valid || in_if.ready) begin
        if (sample_backlog.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = sample_backlog.pop_front();
          in_if.valid   <= 1'b1;
          in_if.sample  <= nxt.sample;
          in_if.restart <= nxt.restart;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each min/max word, then drive ready
  always @(posedge clk or negedge rst_n) begin : check_results
    minmax_word_t exp_w;
    int unsigned  out_words;
    int unsigned  hold_left;
    bit           hold_done;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_words = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_words++;
        if (minmax_due.size() == 0) begin
          $error("unexpected min/max word: window_min %0d, window_max %0d",
                 out_if.window_min, out_if.window_max);
          fails++;
        end else begin
          exp_w = minmax_due.pop_front();
          if (out_if.window_min !== exp_w.lo) begin
            $error("window_min mismatch: expected %0d, actual %0d",
                   $signed(exp_w.lo), out_if.window_min);
            fails++;
          end
          if (out_if.window_max !== exp_w.hi) begin
            $error("window_max mismatch: expected %0d, actual %0d",
                   $signed(exp_w.hi), out_if.window_max);
            fails++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (!hold_done && out_words == HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb_sliding_window_min_max failed");
        $finish;
      end
    end
  end

  task automatic queue_sample(input sample_t s, input logic restart);
    sample_word_t w;
    w.sample  = s;
    w.restart = restart;
    sample_backlog.push_back(w);
    queued++;
  endtask

  // Wait until every word is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_if.valid || minmax_due.size() != 0);
  endtask

  // Let the last sample finish its pops, waiting longer for each entry it may pop
  task automatic settle();
    repeat (16 + work_bound)
      @(posedge clk);
  endtask

  // Write window_len while the block is idle; returns at a falling edge
  task automatic set_window(input int unsigned v);
    wait_drained();
    settle();
    cfg_wdata <= v[CFG_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    win_len = v;
  endtask

  function automatic sample_t next_sample(input int style, input sample_t prev, input bit up);
    int pick;
    pick = style;
    if (style == ST_MIX) pick = $urandom_range(ST_RAMP, ST_WIDE);
    case (pick)
      ST_NARROW: return sample_t'(int'($urandom_range(6, 0)) - 3);
      ST_EXTREME: begin
        case ($urandom_range(4, 0))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          3: return '1;
          default: return sample_t'(1);
        endcase
      end
      ST_RAMP: begin
        if ($urandom_range(19, 0) == 0) return $urandom;
        return up ? prev + $urandom_range(3, 0) : prev - $urandom_range(3, 0);
      end
      default: return $urandom;
    endcase
  endfunction

  // Random phases with a fresh window length each, until target words are queued
  task automatic random_phase(input int unsigned target);
    int unsigned r;
    int unsigned w;
    int unsigned n;
    int          style;
    bit          up;
    bit          fresh;
    sample_t     s;
    while (queued < target) begin
      r = $urandom_range(19, 0);
      if (r == 0)       w = 0;
      else if (r == 1)  w = 1;
      else if (r == 2)  w = 2;
      else if (r == 3)  w = 2047;
      else if (r == 4)  w = WMAX;
      else if (r < 10)  w = $urandom_range(8, 3);
      else if (r < 16)  w = $urandom_range(40, 9);
      else              w = $urandom_range(200, 41);
      // Long windows continue the running sequence so results keep coming
      fresh = (w <= 200) && $urandom_range(1, 0);
      set_window(w);
      style = $urandom_range(ST_MIX, ST_WIDE);
      up    = $urandom_range(1, 0);
      n     = $urandom_range(60, 15);
      s     = $urandom;
      for (int i = 0; i < n; i++) begin
        s = next_sample(style, s, up);
        queue_sample(s, (i == 0 && fresh) || (w <= 200 && $urandom_range(39, 0) == 0));
      end
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window of one: every sample is its own min and max
    queue_sample(S_MAX, 1'b1);
    queue_sample(S_MIN, 1'b0);
    // Zero acts as one
    set_window(0);
    queue_sample('0, 1'b0);
    queue_sample('1, 1'b0);
    queue_sample(S_MAX, 1'b0);
    // Window of three: not-yet-full, equal values, restart mid-sequence
    set_window(3);
    queue_sample(S_MIN, 1'b1);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(sample_t'(5), 1'b0);
    queue_sample(sample_t'(5), 1'b0);
    queue_sample(sample_t'(5), 1'b0);
    queue_sample(sample_t'(-7), 1'b0);
    queue_sample(S_MAX, 1'b1);
    queue_sample(sample_t'(1), 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(sample_t'(2), 1'b0);
    // Grow past the maximum without restart: window stays full, clamps to WMAX
    set_window(2047);
    queue_sample(sample_t'(9), 1'b0);
    queue_sample(sample_t'(-9), 1'b0);

    random_phase(400);

    // Swap idling: sender idles more than receiver
    send_idle_pct = 46;
    recv_idle_pct = 12;

    // Full-size window: rising ramp fills the min deque, then one deep pop
    set_window(2047);
    for (int i = 0; i < WMAX; i++) begin
      queue_sample(sample_t'(-1000000 + 3 * i + int'($urandom_range(2, 0))), i == 0);
    end
    queue_sample(S_MIN, 1'b0);
    for (int i = 0; i < 15; i++) begin
      queue_sample($urandom, 1'b0);
    end

    random_phase(1550);

    // No idling on either side
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(1650);

    wait_drained();
    settle();
    if (fails == 0) begin
      $display("tb_sliding_window_min_max passed");
    end else begin
      $display("tb_sliding_window_min_max failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
